// File: sv/lfs_pkg.sv
// Shared types and constants for the line follower steering core.
// No dependencies; the other sv files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package lfs_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int THR_BITS    = 10;
    localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
    localparam int NUM_LANES   = 9;
    localparam int CNT_BITS    = 4;
    localparam int SPEED_BITS  = 8;
    localparam int PINS_BITS   = 4;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;
    localparam int IDX_BITS    = ADDR_BITS - 2;

    localparam logic [THR_BITS-1:0]   THR_RESET      = THR_BITS'(60);
    localparam logic [SPEED_BITS-1:0] STRAIGHT_RESET = SPEED_BITS'(255);
    localparam logic [SPEED_BITS-1:0] HARD_RESET     = SPEED_BITS'(225);
    localparam logic [SPEED_BITS-1:0] TURN_RESET     = SPEED_BITS'(250);

    localparam logic [IDX_BITS-1:0] REG_THRESHOLD = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] REG_STRAIGHT  = IDX_BITS'(1);
    localparam logic [IDX_BITS-1:0] REG_HARD      = IDX_BITS'(2);
    localparam logic [IDX_BITS-1:0] REG_TURN      = IDX_BITS'(3);

    localparam logic [PINS_BITS-1:0] PINS_FWD    = 4'd9;
    localparam logic [PINS_BITS-1:0] PINS_RIGHT  = 4'd13;
    localparam logic [PINS_BITS-1:0] PINS_LEFT   = 4'd11;
    localparam logic [PINS_BITS-1:0] PINS_HARD_R = 4'd5;
    localparam logic [PINS_BITS-1:0] PINS_HARD_L = 4'd10;
    localparam logic [PINS_BITS-1:0] PINS_STOP   = 4'd15;
    localparam logic [PINS_BITS-1:0] PINS_OFF    = 4'd0;

    typedef enum logic [3:0] {
        ACT_FWD    = 4'd0,
        ACT_SOFT_R = 4'd1,
        ACT_SOFT_L = 4'd2,
        ACT_RIGHT  = 4'd3,
        ACT_LEFT   = 4'd4,
        ACT_HARD_R = 4'd5,
        ACT_HARD_L = 4'd6,
        ACT_STOP   = 4'd7,
        ACT_NONE   = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        TURN_NONE   = 3'd0,
        TURN_SOFT_R = 3'd1,
        TURN_SOFT_L = 3'd2,
        TURN_RIGHT  = 3'd3,
        TURN_LEFT   = 3'd4,
        TURN_HARD_R = 3'd5,
        TURN_HARD_L = 3'd6
    } t_turn;

    typedef struct packed {
        logic [SPEED_BITS-1:0] straight;
        logic [SPEED_BITS-1:0] hard;
        logic [SPEED_BITS-1:0] turn;
    } t_speeds;

    typedef struct packed {
        t_action               action;
        logic [PINS_BITS-1:0]  pins;
        logic                  pins_wr;
        logic [SPEED_BITS-1:0] duty1;
        logic [SPEED_BITS-1:0] duty2;
        logic                  duty_wr;
        logic [NUM_LANES-1:0]  pattern;
        logic [CNT_BITS-1:0]   count;
    } t_result;

    typedef struct packed {
        t_result res;
        logic    turn_wr;
        t_turn   turn;
    } t_decision;

endpackage

// File: sv/lfs_lane.sv
// One sensor lane: strict compare of a sample against the line threshold.
// Depends on lfs_pkg for widths.
`timescale 1ns / 1ps

module lfs_lane (
    input  logic [lfs_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [lfs_pkg::THR_BITS-1:0]    i_threshold,
    output logic                            o_hit
);

    logic [lfs_pkg::CMP_BITS-1:0] w_sample;
    logic [lfs_pkg::CMP_BITS-1:0] w_thr;

    assign w_sample = lfs_pkg::CMP_BITS'(i_sample);
    assign w_thr    = lfs_pkg::CMP_BITS'(i_threshold);
    assign o_hit    = (w_sample > w_thr);

endmodule

// File: sv/lfs_decide.sv
// Merge stage: joins the lane hits into a pattern, counts them, runs the
// priority rule list and turn memory replay. Depends on lfs_pkg.
`timescale 1ns / 1ps

module lfs_decide (
    input  logic [lfs_pkg::NUM_LANES-1:0] i_hits,
    input  lfs_pkg::t_turn                i_last_turn,
    input  lfs_pkg::t_speeds              i_speeds,
    output lfs_pkg::t_decision            o_dec
);

    logic [lfs_pkg::NUM_LANES-1:0] v;
    logic [lfs_pkg::CNT_BITS-1:0]  cnt;
    logic                          fwd_val;
    logic                          right3;
    logic                          left3;
    logic [1:0]                    r01;
    logic [1:0]                    l78;
    lfs_pkg::t_action              act;
    logic                          turn_wr;
    lfs_pkg::t_turn                turn;

    assign v = i_hits;

    always_comb begin
        cnt = '0;
        for (int i = 0; i < lfs_pkg::NUM_LANES; i++) begin
            cnt = cnt + lfs_pkg::CNT_BITS'(v[i]);
        end
    end

    assign fwd_val = (v == 9'd56) || (v == 9'd48) || (v == 9'd24);
    assign right3  = |v[2:0];
    assign left3   = |v[8:6];
    assign r01     = v[1:0];
    assign l78     = v[8:7];

    always_comb begin
        turn_wr = 1'b0;
        turn    = i_last_turn;
        priority if (fwd_val) begin
            act = lfs_pkg::ACT_FWD;
        end else if (v == 9'd28 || v == 9'd12) begin
            act = lfs_pkg::ACT_SOFT_R; turn_wr = 1'b1; turn = lfs_pkg::TURN_SOFT_R;
        end else if (v == 9'd112 || v == 9'd96) begin
            act = lfs_pkg::ACT_SOFT_L; turn_wr = 1'b1; turn = lfs_pkg::TURN_SOFT_L;
        end else if (v == 9'd14 || v == 9'd6) begin
            act = lfs_pkg::ACT_RIGHT; turn_wr = 1'b1; turn = lfs_pkg::TURN_RIGHT;
        end else if (v == 9'd224 || v == 9'd192) begin
            act = lfs_pkg::ACT_LEFT; turn_wr = 1'b1; turn = lfs_pkg::TURN_LEFT;
        end else if (v == 9'd7 || v == 9'd3 || v == 9'd1) begin
            act = lfs_pkg::ACT_HARD_R; turn_wr = 1'b1; turn = lfs_pkg::TURN_HARD_R;
        end else if (v == 9'd448 || v == 9'd384 || v == 9'd256) begin
            act = lfs_pkg::ACT_HARD_L; turn_wr = 1'b1; turn = lfs_pkg::TURN_HARD_L;
        end else if (right3 && left3) begin
            act = lfs_pkg::ACT_RIGHT; turn_wr = 1'b1; turn = lfs_pkg::TURN_RIGHT;
        end else if (fwd_val && r01 == 2'b11) begin
            // shadowed by the forward rule, kept for rule order
            act = lfs_pkg::ACT_HARD_R; turn_wr = 1'b1; turn = lfs_pkg::TURN_HARD_R;
        end else if (fwd_val && l78 == 2'b11) begin
            act = lfs_pkg::ACT_HARD_L; turn_wr = 1'b1; turn = lfs_pkg::TURN_HARD_L;
        end else if ((|r01) && !left3) begin
            act = lfs_pkg::ACT_HARD_R; turn_wr = 1'b1; turn = lfs_pkg::TURN_HARD_R;
        end else if ((|l78) && !right3) begin
            act = lfs_pkg::ACT_HARD_L; turn_wr = 1'b1; turn = lfs_pkg::TURN_HARD_L;
        end else if (v == 9'd511) begin
            act = lfs_pkg::ACT_STOP;
        end else begin
            // replay the remembered turn
            unique case (i_last_turn)
                lfs_pkg::TURN_SOFT_R, lfs_pkg::TURN_RIGHT: act = lfs_pkg::ACT_RIGHT;
                lfs_pkg::TURN_SOFT_L, lfs_pkg::TURN_LEFT:  act = lfs_pkg::ACT_LEFT;
                lfs_pkg::TURN_HARD_R:                      act = lfs_pkg::ACT_HARD_R;
                lfs_pkg::TURN_HARD_L:                      act = lfs_pkg::ACT_HARD_L;
                default:                                   act = lfs_pkg::ACT_NONE;
            endcase
        end
    end

    always_comb begin
        o_dec.res.action  = act;
        o_dec.res.pins    = lfs_pkg::PINS_OFF;
        o_dec.res.pins_wr = 1'b1;
        o_dec.res.duty1   = '0;
        o_dec.res.duty2   = '0;
        o_dec.res.duty_wr = 1'b1;
        o_dec.res.pattern = v;
        o_dec.res.count   = cnt;
        o_dec.turn_wr     = turn_wr;
        o_dec.turn        = turn;
        unique case (act)
            lfs_pkg::ACT_FWD: begin
                o_dec.res.pins  = lfs_pkg::PINS_FWD;
                o_dec.res.duty1 = i_speeds.straight;
                o_dec.res.duty2 = i_speeds.straight;
            end
            lfs_pkg::ACT_SOFT_R: begin
                o_dec.res.pins  = lfs_pkg::PINS_FWD;
                o_dec.res.duty1 = i_speeds.hard;
                o_dec.res.duty2 = i_speeds.turn;
            end
            lfs_pkg::ACT_SOFT_L: begin
                o_dec.res.pins  = lfs_pkg::PINS_FWD;
                o_dec.res.duty1 = i_speeds.turn;
                o_dec.res.duty2 = i_speeds.hard;
            end
            lfs_pkg::ACT_RIGHT: begin
                o_dec.res.pins  = lfs_pkg::PINS_RIGHT;
                o_dec.res.duty1 = i_speeds.turn;
                o_dec.res.duty2 = i_speeds.turn;
            end
            lfs_pkg::ACT_LEFT: begin
                o_dec.res.pins  = lfs_pkg::PINS_LEFT;
                o_dec.res.duty1 = i_speeds.turn;
                o_dec.res.duty2 = i_speeds.turn;
            end
            lfs_pkg::ACT_HARD_R: begin
                o_dec.res.pins  = lfs_pkg::PINS_HARD_R;
                o_dec.res.duty1 = i_speeds.hard;
                o_dec.res.duty2 = i_speeds.hard;
            end
            lfs_pkg::ACT_HARD_L: begin
                o_dec.res.pins  = lfs_pkg::PINS_HARD_L;
                o_dec.res.duty1 = i_speeds.hard;
                o_dec.res.duty2 = i_speeds.hard;
            end
            lfs_pkg::ACT_STOP: begin
                o_dec.res.pins    = lfs_pkg::PINS_STOP;
                o_dec.res.duty_wr = 1'b0;
            end
            default: begin
                o_dec.res.pins_wr = 1'b0;
                o_dec.res.duty_wr = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/line_follow_steering_core.sv
// Top level of the line follower steering core: register port, nine
// comparator lanes, the merge stage and the output register.
// Depends on lfs_pkg, lfs_lane and lfs_decide.
//
//   channel   direction  handshake                    payload
//   frame     in         i_in_valid / o_in_ready      i_sample_0 .. i_sample_8
//   result    out        o_out_valid / i_out_ready    o_action .. o_line_count
//   config    in         psel, penable, pwrite        paddr, pwdata, prdata
//
// One frame per cycle while o_in_ready is high; a result appears in the cycle after its frame is taken.
// The whole frame goes through the lanes and the rule match in the cycle it is taken.
// A result waiting in the output register holds while i_out_ready is low; a
// new frame is still taken in the cycle that result leaves.
// Reset restores the register defaults and clears the turn memory.
`timescale 1ns / 1ps

module line_follow_steering_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lfs_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [lfs_pkg::DATA_BITS-1:0]       pwdata,
    output logic [lfs_pkg::DATA_BITS-1:0]       prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [lfs_pkg::SAMPLE_BITS-1:0]     i_sample_0,
    input  logic [lfs_pkg::SAMPLE_BITS-1:0]     i_sample_1,
    input  logic [lfs_pkg::SAMPLE_BITS-1:0]     i_sample_2,
    input  logic [lfs_pkg::SAMPLE_BITS-1:0]     i_sample_3,
    input  logic [lfs_pkg::SAMPLE_BITS-1:0]     i_sample_4,
    input  logic [lfs_pkg::SAMPLE_BITS-1:0]     i_sample_5,
    input  logic [lfs_pkg::SAMPLE_BITS-1:0]     i_sample_6,
    input  logic [lfs_pkg::SAMPLE_BITS-1:0]     i_sample_7,
    input  logic [lfs_pkg::SAMPLE_BITS-1:0]     i_sample_8,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [3:0]                          o_action,
    output logic [lfs_pkg::PINS_BITS-1:0]       o_bridge_pins,
    output logic                                o_pins_written,
    output logic [lfs_pkg::SPEED_BITS-1:0]      o_duty_first,
    output logic [lfs_pkg::SPEED_BITS-1:0]      o_duty_second,
    output logic                                o_duty_written,
    output logic [lfs_pkg::NUM_LANES-1:0]       o_line_pattern,
    output logic [lfs_pkg::CNT_BITS-1:0]        o_line_count
);

    logic [lfs_pkg::THR_BITS-1:0]   r_thr;
    lfs_pkg::t_speeds               r_speeds;
    lfs_pkg::t_turn                 r_last_turn;
    logic                           r_valid;
    lfs_pkg::t_result               r_res;

    logic [lfs_pkg::SAMPLE_BITS-1:0] w_samples [lfs_pkg::NUM_LANES];
    logic [lfs_pkg::NUM_LANES-1:0]   w_hits;
    lfs_pkg::t_decision              w_dec;
    logic                            w_accept;
    logic                            w_cfg_wr;
    logic [lfs_pkg::IDX_BITS-1:0]    w_idx;

    assign pready   = 1'b1;
    assign w_idx    = paddr[lfs_pkg::ADDR_BITS-1:2];
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr             <= lfs_pkg::THR_RESET;
            r_speeds.straight <= lfs_pkg::STRAIGHT_RESET;
            r_speeds.hard     <= lfs_pkg::HARD_RESET;
            r_speeds.turn     <= lfs_pkg::TURN_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                lfs_pkg::REG_THRESHOLD: r_thr <= pwdata[lfs_pkg::THR_BITS-1:0];
                lfs_pkg::REG_STRAIGHT:  r_speeds.straight <= pwdata[lfs_pkg::SPEED_BITS-1:0];
                lfs_pkg::REG_HARD:      r_speeds.hard <= pwdata[lfs_pkg::SPEED_BITS-1:0];
                lfs_pkg::REG_TURN:      r_speeds.turn <= pwdata[lfs_pkg::SPEED_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lfs_pkg::REG_THRESHOLD: prdata = lfs_pkg::DATA_BITS'(r_thr);
            lfs_pkg::REG_STRAIGHT:  prdata = lfs_pkg::DATA_BITS'(r_speeds.straight);
            lfs_pkg::REG_HARD:      prdata = lfs_pkg::DATA_BITS'(r_speeds.hard);
            lfs_pkg::REG_TURN:      prdata = lfs_pkg::DATA_BITS'(r_speeds.turn);
            default:                prdata = '0;
        endcase
    end

    assign w_samples[0] = i_sample_0;
    assign w_samples[1] = i_sample_1;
    assign w_samples[2] = i_sample_2;
    assign w_samples[3] = i_sample_3;
    assign w_samples[4] = i_sample_4;
    assign w_samples[5] = i_sample_5;
    assign w_samples[6] = i_sample_6;
    assign w_samples[7] = i_sample_7;
    assign w_samples[8] = i_sample_8;

    for (genvar g = 0; g < lfs_pkg::NUM_LANES; g++) begin : g_lane
        lfs_lane u_lane (
            .i_sample    (w_samples[g]),
            .i_threshold (r_thr),
            .o_hit       (w_hits[g])
        );
    end

    lfs_decide u_decide (
        .i_hits      (w_hits),
        .i_last_turn (r_last_turn),
        .i_speeds    (r_speeds),
        .o_dec       (w_dec)
    );

    assign o_in_ready = !r_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_last_turn <= lfs_pkg::TURN_NONE;
        end else if (w_accept) begin
            r_valid <= 1'b1;
            r_res   <= w_dec.res;
            if (w_dec.turn_wr) begin
                r_last_turn <= w_dec.turn;
            end
        end else if (i_out_ready) begin
            // drop the delivered transaction
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_action       = r_res.action;
    assign o_bridge_pins  = r_res.pins;
    assign o_pins_written = r_res.pins_wr;
    assign o_duty_first   = r_res.duty1;
    assign o_duty_second  = r_res.duty2;
    assign o_duty_written = r_res.duty_wr;
    assign o_line_pattern = r_res.pattern;
    assign o_line_count   = r_res.count;

endmodule

// File: sv/lfs_checker.sv
// Port-level checks for line_follow_steering_core, bound to the top level.
// Depends on lfs_pkg for widths and action codes.
`timescale 1ns / 1ps

module lfs_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [3:0]                          o_action,
    input  logic [lfs_pkg::PINS_BITS-1:0]       o_bridge_pins,
    input  logic                                o_pins_written,
    input  logic                                o_duty_written,
    input  logic [lfs_pkg::NUM_LANES-1:0]       o_line_pattern,
    input  logic [lfs_pkg::CNT_BITS-1:0]        o_line_count
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_line_pattern))
        else $error("result dropped or changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_line_count == lfs_pkg::CNT_BITS'($countones(o_line_pattern)))
        else $error("line count does not match pattern");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == lfs_pkg::ACT_NONE |->
            !o_pins_written && !o_duty_written && o_bridge_pins == lfs_pkg::PINS_OFF)
        else $error("outputs driven with empty turn memory");

    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == lfs_pkg::ACT_STOP |->
            !o_duty_written && o_pins_written && o_bridge_pins == lfs_pkg::PINS_STOP)
        else $error("stop drives duties or wrong pins");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind line_follow_steering_core lfs_checker u_lfs_checker (.*);

// File: verif/line_follow_steering_core_test.sv
// Self-checking testbench for line_follow_steering_core: directed frames, then
// random frames under several register settings, checked by a built-in predictor.
// Depends on lfs_pkg and line_follow_steering_core.
`timescale 1ns / 1ps

module line_follow_steering_core_test;
    import lfs_pkg::*;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [NUM_LANES-1:0] t_frame;

    // one directed frame: lanes set in pat read hi, the others read lo
    typedef struct packed {
        logic [NUM_LANES-1:0] pat;
        t_sample              hi;
        t_sample              lo;
        logic                 typed;
        t_result              want;
    } t_row;

    localparam t_sample SAMPLE_MAX = '1;
    localparam int      WATCHDOG_LIMIT = 1000;
    localparam int      PLAN_ROWS = 26;

    localparam t_row PLAN [PLAN_ROWS] = '{
        '{9'd0,   SAMPLE_MAX, 10'd0,  1'b1,
          '{ACT_NONE, PINS_OFF, 1'b0, 8'd0, 8'd0, 1'b0, 9'd0, 4'd0}},
        '{9'd511, 10'd60,     10'd60, 1'b1,
          '{ACT_NONE, PINS_OFF, 1'b0, 8'd0, 8'd0, 1'b0, 9'd0, 4'd0}},
        '{9'd511, SAMPLE_MAX, 10'd0,  1'b1,
          '{ACT_RIGHT, PINS_RIGHT, 1'b1, 8'd250, 8'd250, 1'b1, 9'd511, 4'd9}},
        '{9'd0,   SAMPLE_MAX, 10'd0,  1'b1,
          '{ACT_RIGHT, PINS_RIGHT, 1'b1, 8'd250, 8'd250, 1'b1, 9'd0, 4'd0}},
        '{9'd56,  10'd61,     10'd60, 1'b1,
          '{ACT_FWD, PINS_FWD, 1'b1, 8'd255, 8'd255, 1'b1, 9'd56, 4'd3}},
        '{9'd28,  SAMPLE_MAX, 10'd0,  1'b1,
          '{ACT_SOFT_R, PINS_FWD, 1'b1, 8'd225, 8'd250, 1'b1, 9'd28, 4'd3}},
        '{9'd16,  SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd112, SAMPLE_MAX, 10'd0,  1'b1,
          '{ACT_SOFT_L, PINS_FWD, 1'b1, 8'd250, 8'd225, 1'b1, 9'd112, 4'd3}},
        '{9'd16,  SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd14,  SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd224, SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd0,   SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd7,   SAMPLE_MAX, 10'd0,  1'b1,
          '{ACT_HARD_R, PINS_HARD_R, 1'b1, 8'd225, 8'd225, 1'b1, 9'd7, 4'd3}},
        '{9'd0,   SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd448, SAMPLE_MAX, 10'd0,  1'b1,
          '{ACT_HARD_L, PINS_HARD_L, 1'b1, 8'd225, 8'd225, 1'b1, 9'd448, 4'd3}},
        '{9'd0,   SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd48,  SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd12,  SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd96,  SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd6,   SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd192, SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd3,   SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd384, SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd2,   SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd128, SAMPLE_MAX, 10'd0,  1'b0, '0},
        '{9'd65,  SAMPLE_MAX, 10'd0,  1'b0, '0}
    };

    localparam logic [NUM_LANES-1:0] RULE_PATS [18] = '{
        9'd56, 9'd48, 9'd24, 9'd28, 9'd12, 9'd112, 9'd96, 9'd14, 9'd6,
        9'd224, 9'd192, 9'd7, 9'd3, 9'd1, 9'd448, 9'd384, 9'd256, 9'd511
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_BITS-1:0]  paddr = '0;
    logic [DATA_BITS-1:0]  pwdata = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_sample               i_sample_0 = '0, i_sample_1 = '0, i_sample_2 = '0;
    t_sample               i_sample_3 = '0, i_sample_4 = '0, i_sample_5 = '0;
    t_sample               i_sample_6 = '0, i_sample_7 = '0, i_sample_8 = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [3:0]            o_action;
    logic [PINS_BITS-1:0]  o_bridge_pins;
    logic                  o_pins_written;
    logic [SPEED_BITS-1:0] o_duty_first;
    logic [SPEED_BITS-1:0] o_duty_second;
    logic                  o_duty_written;
    logic [NUM_LANES-1:0]  o_line_pattern;
    logic [CNT_BITS-1:0]   o_line_count;

    // predictor copy of the registers and the turn memory
    logic [THR_BITS-1:0]   line_thr = THR_RESET;
    t_speeds               speeds = '{STRAIGHT_RESET, HARD_RESET, TURN_RESET};
    t_turn                 turn_mem = TURN_NONE;

    t_result               results_due[$];
    logic                  row_typed = 1'b0;
    t_result               row_want = '0;
    int unsigned           mismatches = 0;
    int unsigned           quiet = 0;
    int unsigned           tx_idle_pct = 7;
    int unsigned           rx_idle_pct = 74;
    logic                  calm = 1'b0;

    line_follow_steering_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_0     (i_sample_0),
        .i_sample_1     (i_sample_1),
        .i_sample_2     (i_sample_2),
        .i_sample_3     (i_sample_3),
        .i_sample_4     (i_sample_4),
        .i_sample_5     (i_sample_5),
        .i_sample_6     (i_sample_6),
        .i_sample_7     (i_sample_7),
        .i_sample_8     (i_sample_8),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action       (o_action),
        .o_bridge_pins  (o_bridge_pins),
        .o_pins_written (o_pins_written),
        .o_duty_first   (o_duty_first),
        .o_duty_second  (o_duty_second),
        .o_duty_written (o_duty_written),
        .o_line_pattern (o_line_pattern),
        .o_line_count   (o_line_count)
    );

    always #4 i_clk = ~i_clk;

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // steering decision for one frame; advances the turn memory
    function automatic t_result steer(input t_frame f);
        t_result              r;
        logic [NUM_LANES-1:0] v;
        logic [CNT_BITS-1:0]  n;
        t_action              act;
        int                   i;
        v = '0;
        n = '0;
        for (i = 0; i < NUM_LANES; i++) begin
            if (f[i] > line_thr) begin
                v[i] = 1'b1;
                n = n + 1'b1;
            end
        end
        if (v == 9'd56 || v == 9'd48 || v == 9'd24) begin
            act = ACT_FWD;
        end else if (v == 9'd28 || v == 9'd12) begin
            act = ACT_SOFT_R; turn_mem = TURN_SOFT_R;
        end else if (v == 9'd112 || v == 9'd96) begin
            act = ACT_SOFT_L; turn_mem = TURN_SOFT_L;
        end else if (v == 9'd14 || v == 9'd6) begin
            act = ACT_RIGHT; turn_mem = TURN_RIGHT;
        end else if (v == 9'd224 || v == 9'd192) begin
            act = ACT_LEFT; turn_mem = TURN_LEFT;
        end else if (v == 9'd7 || v == 9'd3 || v == 9'd1) begin
            act = ACT_HARD_R; turn_mem = TURN_HARD_R;
        end else if (v == 9'd448 || v == 9'd384 || v == 9'd256) begin
            act = ACT_HARD_L; turn_mem = TURN_HARD_L;
        end else if (v[2:0] != 0 && v[8:6] != 0) begin
            act = ACT_RIGHT; turn_mem = TURN_RIGHT;
        // forward patterns were taken above, so the forward-with-edge rules never fire
        end else if (v[1:0] != 0 && v[8:6] == 0) begin
            act = ACT_HARD_R; turn_mem = TURN_HARD_R;
        end else if (v[8:7] != 0 && v[2:0] == 0) begin
            act = ACT_HARD_L; turn_mem = TURN_HARD_L;
        end else if (v == '1) begin
            act = ACT_STOP;
        end else begin
            case (turn_mem)
                TURN_SOFT_R, TURN_RIGHT: act = ACT_RIGHT;
                TURN_SOFT_L, TURN_LEFT:  act = ACT_LEFT;
                TURN_HARD_R:             act = ACT_HARD_R;
                TURN_HARD_L:             act = ACT_HARD_L;
                default:                 act = ACT_NONE;
            endcase
        end
        r = '0;
        r.action = act;
        r.pins_wr = 1'b1;
        r.duty_wr = 1'b1;
        case (act)
            ACT_FWD: begin
                r.pins = PINS_FWD; r.duty1 = speeds.straight; r.duty2 = speeds.straight;
            end
            ACT_SOFT_R: begin
                r.pins = PINS_FWD; r.duty1 = speeds.hard; r.duty2 = speeds.turn;
            end
            ACT_SOFT_L: begin
                r.pins = PINS_FWD; r.duty1 = speeds.turn; r.duty2 = speeds.hard;
            end
            ACT_RIGHT: begin
                r.pins = PINS_RIGHT; r.duty1 = speeds.turn; r.duty2 = speeds.turn;
            end
            ACT_LEFT: begin
                r.pins = PINS_LEFT; r.duty1 = speeds.turn; r.duty2 = speeds.turn;
            end
            ACT_HARD_R: begin
                r.pins = PINS_HARD_R; r.duty1 = speeds.hard; r.duty2 = speeds.hard;
            end
            ACT_HARD_L: begin
                r.pins = PINS_HARD_L; r.duty1 = speeds.hard; r.duty2 = speeds.hard;
            end
            ACT_STOP: begin
                r.pins = PINS_STOP; r.duty_wr = 1'b0;
            end
            default: begin
                r.pins_wr = 1'b0; r.duty_wr = 1'b0;
            end
        endcase
        r.pattern = v;
        r.count = n;
        return r;
    endfunction

    // samples that give pattern p under the current threshold, now and then pure noise
    function automatic t_frame make_frame(input logic [NUM_LANES-1:0] p);
        t_frame      f;
        int unsigned t;
        logic        noisy;
        int          i;
        t = line_thr;
        noisy = ($urandom_range(9) == 0);
        for (i = 0; i < NUM_LANES; i++) begin
            if (noisy || (p[i] && t >= SAMPLE_MAX))
                f[i] = t_sample'($urandom_range(SAMPLE_MAX));
            else if (p[i])
                f[i] = ($urandom_range(3) == 0) ? t_sample'(t + 1)
                                                : t_sample'($urandom_range(SAMPLE_MAX, t + 1));
            else
                f[i] = ($urandom_range(3) == 0) ? t_sample'(t) : t_sample'($urandom_range(t, 0));
        end
        return f;
    endfunction

    function automatic logic [NUM_LANES-1:0] pick_pattern();
        logic [NUM_LANES-1:0] p;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: p = RULE_PATS[$urandom_range(17)];
            6: p = RULE_PATS[$urandom_range(17)] ^ (9'd1 << $urandom_range(8));
            7: p = NUM_LANES'($urandom);
            default: p = '0;
        endcase
        return p;
    endfunction

    task automatic apb_access(input logic wr, input logic [IDX_BITS-1:0] idx,
                              input logic [31:0] data, output logic [31:0] rd);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // write with junk above the register width, then read it back
    task automatic reg_write(input logic [IDX_BITS-1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] rd;
        mask = (idx == REG_THRESHOLD) ? 32'h3FF : 32'hFF;
        apb_access(1'b1, idx, (value & mask) | ($urandom & ~mask), rd);
        case (idx)
            REG_THRESHOLD: line_thr = value[THR_BITS-1:0];
            REG_STRAIGHT:  speeds.straight = value[SPEED_BITS-1:0];
            REG_HARD:      speeds.hard = value[SPEED_BITS-1:0];
            REG_TURN:      speeds.turn = value[SPEED_BITS-1:0];
            default: ;
        endcase
        apb_access(1'b0, idx, '0, rd);
        check_field("prdata", value & mask, rd);
    endtask

    task automatic program_regs(input int unsigned thr, input int unsigned straight,
                                input int unsigned hard, input int unsigned turn);
        reg_write(REG_THRESHOLD, thr);
        reg_write(REG_STRAIGHT, straight);
        reg_write(REG_HARD, hard);
        reg_write(REG_TURN, turn);
    endtask

    // drop valid and drain every pending result
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic push_frame(input t_frame f, input logic typed, input t_result want);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_0 <= f[0];
        i_sample_1 <= f[1];
        i_sample_2 <= f[2];
        i_sample_3 <= f[3];
        i_sample_4 <= f[4];
        i_sample_5 <= f[5];
        i_sample_6 <= f[6];
        i_sample_7 <= f[7];
        i_sample_8 <= f[8];
        row_typed <= typed;
        row_want <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= rx_idle_pct);
    end

    // check the result leaving first, then queue the prediction for the frame taken
    always @(posedge i_clk) begin : score
        t_result want;
        logic    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (results_due.size() == 0) begin
                    $error("result transaction with no frame pending");
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("action", want.action, o_action);
                    check_field("bridge_pins", want.pins, o_bridge_pins);
                    check_field("pins_written", want.pins_wr, o_pins_written);
                    check_field("duty_first", want.duty1, o_duty_first);
                    check_field("duty_second", want.duty2, o_duty_second);
                    check_field("duty_written", want.duty_wr, o_duty_written);
                    check_field("line_pattern", want.pattern, o_line_pattern);
                    check_field("line_count", want.count, o_line_count);
                end
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                want = steer({i_sample_8, i_sample_7, i_sample_6, i_sample_5, i_sample_4,
                              i_sample_3, i_sample_2, i_sample_1, i_sample_0});
                results_due.push_back(row_typed ? row_want : want);
            end
            if (psel && penable && pready)
                moved = 1'b1;
            quiet <= moved ? 0 : quiet + 1;
        end
    end

    // quiet stretches in a correct run stay far below this, even at the heaviest stall rate
    always @(posedge i_clk) begin
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("line_follow_steering_core test failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_frame      f;
        int          r;
        int          i;
        int          ph;
        int          k;
        int unsigned items;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames under the reset register values
        for (r = 0; r < PLAN_ROWS; r++) begin
            for (i = 0; i < NUM_LANES; i++)
                f[i] = PLAN[r].pat[i] ? PLAN[r].hi : PLAN[r].lo;
            push_frame(f, PLAN[r].typed, PLAN[r].want);
        end

        for (ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin
                    program_regs(0, 0, 255, 128);
                    items = 200;
                end
                1: begin
                    program_regs(1023, 255, 0, 255);
                    items = 60;
                end
                2: begin
                    program_regs(512, $urandom_range(255), $urandom_range(255),
                                 $urandom_range(255));
                    tx_idle_pct = 74;
                    rx_idle_pct = 7;
                    items = 220;
                end
                3: begin
                    program_regs(1022, 1, 254, 0);
                    items = 200;
                end
                4: begin
                    program_regs($urandom_range(1023), $urandom_range(255),
                                 $urandom_range(255), $urandom_range(255));
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    items = 220;
                end
                default: begin
                    program_regs(60, 255, 225, 250);
                    items = 225;
                end
            endcase
            for (k = 0; k < items; k++) begin
                calm = (k % 60) >= 48;
                push_frame(make_frame(pick_pattern()), 1'b0, '0);
            end
            calm = 1'b0;
        end

        settle();
        if (mismatches == 0)
            $display("line_follow_steering_core test passed");
        else
            $display("line_follow_steering_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/lfs_pkg.sv
sv/lfs_lane.sv
sv/lfs_decide.sv
sv/line_follow_steering_core.sv
sv/lfs_checker.sv
verif/line_follow_steering_core_test.sv
